>>> rtl/core/dcr_pkg.sv
// ----------------------------------------------------------------------------
// dcr_pkg
// shared types and constants for the dual uart console register block
// ----------------------------------------------------------------------------
package dcr_pkg;

    // item opcodes
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_RX    = 2'd2,
        OP_IDLE  = 2'd3
    } dcr_op_t;

    // register byte offsets
    localparam logic [4:0] OFF_MRA  = 5'h00;
    localparam logic [4:0] OFF_SRA  = 5'h02;
    localparam logic [4:0] OFF_CRA  = 5'h04;
    localparam logic [4:0] OFF_RHRA = 5'h06;
    localparam logic [4:0] OFF_ISR  = 5'h0A;
    localparam logic [4:0] OFF_MRB  = 5'h10;
    localparam logic [4:0] OFF_SRB  = 5'h12;
    localparam logic [4:0] OFF_CRB  = 5'h14;
    localparam logic [4:0] OFF_THRB = 5'h16;
    localparam logic [4:0] OFF_IVR  = 5'h18;

    // status and command codes
    localparam logic [7:0] SR_BASE      = 8'h0C;
    localparam logic [7:0] SR_RXRDY     = 8'h01;
    localparam logic [7:0] ISR_BASE     = 8'h11;
    localparam logic [7:0] ISR_RXRDY    = 8'h02;
    localparam logic [2:0] CMD_RESET_MR = 3'h1;
    localparam logic [2:0] IRQ_LEVEL    = 3'd3;

    // input word
    typedef struct packed {
        logic [1:0] opcode;
        logic [4:0] reg_offset;
        logic [7:0] write_data;
        logic [7:0] rx_byte;
    } dcr_in_t;

    // result word
    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [2:0] irq_level;
        logic [7:0] irq_vector;
        logic       rx_dropped;
        logic [4:0] rx_space;
    } dcr_out_t;

    // fifo control from the register decode
    typedef struct packed {
        logic push;
        logic pop;
    } dcr_fifo_ctl_t;

    // fifo status back to the register decode
    typedef struct packed {
        logic       not_empty;
        logic       full;
        logic       not_empty_next;
        logic [4:0] space_next;
    } dcr_fifo_stat_t;

endpackage

>>> rtl/core/dcr_rx_fifo.sv
// ----------------------------------------------------------------------------
// dcr_rx_fifo
// receive fifo with a registered head word and write-to-head bypass
// ----------------------------------------------------------------------------
module dcr_rx_fifo import dcr_pkg::*; #(
    parameter int RX_DEPTH = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  dcr_fifo_ctl_t  ctl,
    input  logic [7:0]     push_data,
    output logic [7:0]     head_data,
    output dcr_fifo_stat_t stat
);

    localparam int PTR_W  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int FILL_W = $clog2(RX_DEPTH + 1);

    logic [7:0]        mem [RX_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        head_reg;
    logic [31:0]       space_w;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(RX_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = ctl.push ? next_slot(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = ctl.pop ? next_slot(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (ctl.push && !ctl.pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (ctl.pop && !ctl.push) begin
            fill_next = fill_reg - 1'b1;
        end
        space_w = 32'(RX_DEPTH) - 32'(fill_next);
    end

    assign stat.not_empty      = (fill_reg != '0);
    assign stat.full           = (fill_reg == FILL_W'(RX_DEPTH));
    assign stat.not_empty_next = (fill_next != '0);
    assign stat.space_next     = space_w[4:0];
    assign head_data           = head_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage write port
    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // registered read of the next head, bypassing a write into that slot
    always_ff @(posedge aclk) begin
        if (ctl.push && (wr_ptr_reg == rd_ptr_next)) begin
            head_reg <= push_data;
        end else begin
            head_reg <= mem[rd_ptr_next];
        end
    end

endmodule

>>> rtl/core/dcr_chan_regs.sv
// ----------------------------------------------------------------------------
// dcr_chan_regs
// register decode, mode/interrupt registers and result formation
// ----------------------------------------------------------------------------
module dcr_chan_regs import dcr_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           fire,
    input  dcr_in_t        item,
    input  logic [7:0]     fifo_head,
    input  dcr_fifo_stat_t fifo_stat,
    output dcr_fifo_ctl_t  fifo_ctl,
    output dcr_out_t       result
);

    logic [7:0] mra_reg [2];
    logic [7:0] mrb_reg [2];
    logic       ptr_a_reg, ptr_a_next;
    logic       ptr_b_reg, ptr_b_next;
    logic [7:0] imr_reg, imr_next;
    logic [7:0] ivr_reg, ivr_next;
    logic       mra_we, mrb_we;
    logic [7:0] rd;
    logic       txv;
    logic       drop;
    logic       pend;
    dcr_op_t    op;

    always_comb begin
        op         = dcr_op_t'(item.opcode);
        rd         = '0;
        txv        = 1'b0;
        drop       = 1'b0;
        ptr_a_next = ptr_a_reg;
        ptr_b_next = ptr_b_reg;
        imr_next   = imr_reg;
        ivr_next   = ivr_reg;
        mra_we     = 1'b0;
        mrb_we     = 1'b0;
        fifo_ctl   = '0;
        unique case (op)
            OP_READ: begin
                unique case (item.reg_offset)
                    OFF_MRA: begin
                        rd         = mra_reg[ptr_a_reg];
                        ptr_a_next = 1'b1;
                    end
                    OFF_SRA:  rd = SR_BASE | (fifo_stat.not_empty ? SR_RXRDY : 8'h00);
                    OFF_RHRA: begin
                        if (fifo_stat.not_empty) begin
                            rd           = fifo_head;
                            fifo_ctl.pop = fire;
                        end
                    end
                    OFF_ISR:  rd = ISR_BASE | (fifo_stat.not_empty ? ISR_RXRDY : 8'h00);
                    OFF_MRB: begin
                        rd         = mrb_reg[ptr_b_reg];
                        ptr_b_next = 1'b1;
                    end
                    OFF_SRB:  rd = SR_BASE;
                    OFF_IVR:  rd = ivr_reg;
                    default:  rd = '0;
                endcase
            end
            OP_WRITE: begin
                unique case (item.reg_offset)
                    OFF_MRA: begin
                        mra_we     = 1'b1;
                        ptr_a_next = 1'b1;
                    end
                    OFF_CRA: begin
                        if (item.write_data[6:4] == CMD_RESET_MR) begin
                            ptr_a_next = 1'b0;
                        end
                    end
                    OFF_RHRA: txv = 1'b1;
                    OFF_MRB: begin
                        mrb_we     = 1'b1;
                        ptr_b_next = 1'b1;
                    end
                    OFF_CRB: begin
                        if (item.write_data[6:4] == CMD_RESET_MR) begin
                            ptr_b_next = 1'b0;
                        end
                    end
                    OFF_ISR:  imr_next = item.write_data;
                    OFF_IVR:  ivr_next = item.write_data;
                    default:  txv = 1'b0;
                endcase
            end
            OP_RX: begin
                if (fifo_stat.full) begin
                    drop = 1'b1;
                end else begin
                    fifo_ctl.push = fire;
                end
            end
            default: rd = '0;
        endcase

        // interrupt state as seen after this word
        pend = imr_next[0] || (imr_next[1] && fifo_stat.not_empty_next);

        result.read_data  = rd;
        result.tx_valid   = txv;
        result.tx_byte    = txv ? item.write_data : 8'h00;
        result.irq_level  = pend ? IRQ_LEVEL : 3'd0;
        result.irq_vector = pend ? ivr_next : 8'h00;
        result.rx_dropped = drop;
        result.rx_space   = fifo_stat.space_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_a_reg  <= 1'b0;
            ptr_b_reg  <= 1'b0;
            imr_reg    <= '0;
            ivr_reg    <= '0;
            mra_reg[0] <= '0;
            mra_reg[1] <= '0;
            mrb_reg[0] <= '0;
            mrb_reg[1] <= '0;
        end else if (fire) begin
            ptr_a_reg <= ptr_a_next;
            ptr_b_reg <= ptr_b_next;
            imr_reg   <= imr_next;
            ivr_reg   <= ivr_next;
            if (mra_we) begin
                mra_reg[ptr_a_reg] <= item.write_data;
            end
            if (mrb_we) begin
                mrb_reg[ptr_b_reg] <= item.write_data;
            end
        end
    end

endmodule

>>> rtl/core/duart_console_channel_regs_top.sv
// ----------------------------------------------------------------------------
// duart_console_channel_regs_top
// dual uart console register block: bus reads/writes and host receive bytes
// a word passes the input register, one decode/update pass and the result register
// throughput: one word per cycle while m_ready does not stall, set by the single
// decode/update pass; backpressure on m_ready holds the result register and
// stalls the input register; reset (aresetn, synchronous, active low) clears
// valid flags, mode/irq registers, pointers and the fifo count; data registers
// and fifo storage are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module duart_console_channel_regs_top import dcr_pkg::*; #(
    parameter int RX_DEPTH = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dcr_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output dcr_out_t m_data
);

    // input register
    logic           in_valid_reg;
    dcr_in_t        in_data_reg;

    // result register
    logic           out_valid_reg;
    dcr_out_t       out_data_reg;

    logic           adv;
    logic           fire;
    dcr_out_t       result;
    dcr_fifo_ctl_t  fifo_ctl;
    dcr_fifo_stat_t fifo_stat;
    logic [7:0]     fifo_head;

    // result register can take a word when empty or being drained
    assign adv     = !out_valid_reg || m_ready;
    // the word in the input register is processed and its state committed
    assign fire    = in_valid_reg && adv;
    assign s_ready = !in_valid_reg || adv;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= result;
        end
    end

    // register decode and interrupt logic
    dcr_chan_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (in_data_reg),
        .fifo_head (fifo_head),
        .fifo_stat (fifo_stat),
        .fifo_ctl  (fifo_ctl),
        .result    (result)
    );

    // channel a receive fifo
    dcr_rx_fifo #(
        .RX_DEPTH (RX_DEPTH)
    ) u_rx_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (fifo_ctl),
        .push_data (in_data_reg.rx_byte),
        .head_data (fifo_head),
        .stat      (fifo_stat)
    );

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the dual uart console register block against a predictor of its
// register, mode pointer, receive fifo and interrupt behavior. Every accepted
// result word is compared field by field with the oldest prediction. Both
// sides idle at random, and there is one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb import dcr_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RX_DEPTH = 16;

    // clock and reset
    logic aclk;
    logic aresetn;

    // input channel
    logic    s_valid;
    logic    s_ready;
    dcr_in_t s_data;

    // result channel
    logic     m_valid;
    logic     m_ready;
    dcr_out_t m_data;

    duart_console_channel_regs_top #(
        .RX_DEPTH(RX_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 10 ns clock period
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // predictor state: a shadow of the mode, interrupt and fifo state the block holds
    // ------------------------------------------------------------------
    logic [7:0] mr_a [2];
    logic       mr_a_ptr;
    logic [7:0] mr_b [2];
    logic       mr_b_ptr;
    logic [7:0] imr_shadow;
    logic [7:0] ivr_shadow;
    logic [7:0] rx_fifo_model [$];     // receive fifo contents, oldest first

    dcr_out_t pending_results [$];     // predicted result words, oldest first
    int       error_count = 0;
    int       results_seen = 0;

    // knobs for the two idling processes
    bit source_gaps = 1'b0;            // sender inserts random gaps
    bit sink_stalls = 1'b0;            // receiver drops m_ready at random
    int long_hold_req = 0;             // one-shot long hold-off request, in cycles

    // ------------------------------------------------------------------
    // predictor: applies one word to the shadow state, returns its result
    // ------------------------------------------------------------------
    function automatic dcr_out_t duart_predict(dcr_in_t w);
        dcr_out_t r;
        bit       has_data;
        bit       irq_on;
        r = '0;
        has_data = (rx_fifo_model.size() != 0);
        case (w.opcode)
            OP_READ: begin
                case (w.reg_offset)
                    OFF_MRA: begin
                        r.read_data = mr_a[mr_a_ptr];
                        mr_a_ptr = 1'b1;
                    end
                    OFF_SRA:  r.read_data = SR_BASE | (has_data ? SR_RXRDY : 8'h00);
                    // popping an empty fifo reads zero and changes nothing
                    OFF_RHRA: if (has_data) r.read_data = rx_fifo_model.pop_front();
                    OFF_ISR:  r.read_data = ISR_BASE | (has_data ? ISR_RXRDY : 8'h00);
                    OFF_MRB: begin
                        r.read_data = mr_b[mr_b_ptr];
                        mr_b_ptr = 1'b1;
                    end
                    OFF_SRB:  r.read_data = SR_BASE;
                    OFF_IVR:  r.read_data = ivr_shadow;
                    default:  ;  // unmapped or write-only: reads zero
                endcase
            end
            OP_WRITE: begin
                case (w.reg_offset)
                    OFF_MRA: begin
                        mr_a[mr_a_ptr] = w.write_data;
                        mr_a_ptr = 1'b1;
                    end
                    OFF_CRA:  if (w.write_data[6:4] == CMD_RESET_MR) mr_a_ptr = 1'b0;
                    OFF_RHRA: begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = w.write_data;
                    end
                    OFF_MRB: begin
                        mr_b[mr_b_ptr] = w.write_data;
                        mr_b_ptr = 1'b1;
                    end
                    OFF_CRB:  if (w.write_data[6:4] == CMD_RESET_MR) mr_b_ptr = 1'b0;
                    OFF_ISR:  imr_shadow = w.write_data;
                    OFF_IVR:  ivr_shadow = w.write_data;
                    default:  ;  // channel b transmit, read-only and unmapped
                endcase
            end
            OP_RX: begin
                if (rx_fifo_model.size() >= RX_DEPTH) r.rx_dropped = 1'b1;
                else rx_fifo_model.push_back(w.rx_byte);
            end
            default: ;  // idle word only reports current state
        endcase
        irq_on = imr_shadow[0] || (imr_shadow[1] && rx_fifo_model.size() != 0);
        if (irq_on) begin
            r.irq_level  = IRQ_LEVEL;
            r.irq_vector = ivr_shadow;
        end
        r.rx_space = 5'(RX_DEPTH - rx_fifo_model.size());
        return r;
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (error_count < 40) $display("%0t: mismatch on result %0d: %s", $realtime,
                                       results_seen, msg);
        error_count++;
    endtask

    task automatic compare_result(input dcr_out_t got, input dcr_out_t exp);
        if (got.read_data !== exp.read_data)
            report_mismatch($sformatf("read_data %h, expected %h", got.read_data,
                                      exp.read_data));
        if (got.tx_valid !== exp.tx_valid)
            report_mismatch($sformatf("tx_valid %b, expected %b", got.tx_valid,
                                      exp.tx_valid));
        if (got.tx_byte !== exp.tx_byte)
            report_mismatch($sformatf("tx_byte %h, expected %h", got.tx_byte,
                                      exp.tx_byte));
        if (got.irq_level !== exp.irq_level)
            report_mismatch($sformatf("irq_level %0d, expected %0d", got.irq_level,
                                      exp.irq_level));
        if (got.irq_vector !== exp.irq_vector)
            report_mismatch($sformatf("irq_vector %h, expected %h", got.irq_vector,
                                      exp.irq_vector));
        if (got.rx_dropped !== exp.rx_dropped)
            report_mismatch($sformatf("rx_dropped %b, expected %b", got.rx_dropped,
                                      exp.rx_dropped));
        if (got.rx_space !== exp.rx_space)
            report_mismatch($sformatf("rx_space %0d, expected %0d", got.rx_space,
                                      exp.rx_space));
    endtask

    // values read just after the edge are the ones the block saw at that edge,
    // since every signal that changes at the edge changes through an nba
    always @(posedge aclk) begin : result_check
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) report_mismatch("result word with nothing expected");
            else compare_result(m_data, pending_results.pop_front());
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // idling: mostly short gaps, now and then a long one
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 70) return $urandom_range(1, 2);
        if (k < 92) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls plus the one long hold-off, counted here
    initial begin : result_sink
        int hold;
        hold = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_hold_req != 0) begin
                hold = long_hold_req;
                long_hold_req = 0;
            end else if (hold == 0 && sink_stalls && $urandom_range(0, 99) < 20) begin
                hold = pick_gap();
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // sender: offers one word, waits for it to be taken, predicts, then
    // maybe idles; valid stays high when the next word follows at once
    // ------------------------------------------------------------------
    task automatic send_word(input dcr_in_t w);
        int gap;
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(duart_predict(w));
        if (source_gaps && $urandom_range(0, 99) < 30) begin
            gap = pick_gap();
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic bus_read(input logic [4:0] off);
        dcr_in_t w;
        w = '{opcode: OP_READ, reg_offset: off, write_data: 8'($urandom_range(0, 255)),
              rx_byte: 8'($urandom_range(0, 255))};
        send_word(w);
    endtask

    task automatic bus_write(input logic [4:0] off, input logic [7:0] val);
        dcr_in_t w;
        w = '{opcode: OP_WRITE, reg_offset: off, write_data: val,
              rx_byte: 8'($urandom_range(0, 255))};
        send_word(w);
    endtask

    task automatic host_byte(input logic [7:0] b);
        dcr_in_t w;
        w = '{opcode: OP_RX, reg_offset: 5'($urandom_range(0, 31)),
              write_data: 8'($urandom_range(0, 255)), rx_byte: b};
        send_word(w);
    endtask

    // sender goes quiet until every predicted word has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // random word generation
    // ------------------------------------------------------------------
    function automatic logic [4:0] pick_offset();
        if ($urandom_range(0, 99) < 15) return 5'($urandom_range(0, 31));
        case ($urandom_range(0, 11))
            0:       return OFF_MRA;
            1:       return OFF_SRA;
            2:       return OFF_CRA;
            3, 4, 5: return OFF_RHRA;
            6:       return OFF_ISR;
            7:       return OFF_MRB;
            8:       return OFF_SRB;
            9:       return OFF_CRB;
            10:      return OFF_THRB;
            default: return OFF_IVR;
        endcase
    endfunction

    function automatic dcr_in_t rand_word();
        dcr_in_t     w;
        int unsigned k;
        w.write_data = 8'($urandom_range(0, 255));
        w.rx_byte    = 8'($urandom_range(0, 255));
        w.reg_offset = pick_offset();
        k = $urandom_range(0, 99);
        if (k < 35)      w.opcode = OP_READ;
        else if (k < 65) w.opcode = OP_WRITE;
        else if (k < 95) w.opcode = OP_RX;
        else             w.opcode = OP_IDLE;
        // make the mode pointer reset command common
        if (w.opcode == OP_WRITE && (w.reg_offset == OFF_CRA || w.reg_offset == OFF_CRB)
            && $urandom_range(0, 1) == 1)
            w.write_data[6:4] = CMD_RESET_MR;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // registers straight out of reset, empty fifo pop, unmapped and write-only reads
    task automatic test_reset_state();
        bus_read(OFF_SRA);
        bus_read(OFF_RHRA);
        bus_read(OFF_ISR);
        bus_read(OFF_SRB);
        bus_read(OFF_IVR);
        bus_read(5'h1F);
        bus_read(OFF_CRA);
    endtask

    // mode register pointer on both channels, including reset command with bit 7 set
    task automatic test_mode_pointers();
        bus_write(OFF_MRA, 8'hFF);
        bus_write(OFF_MRA, 8'h00);
        bus_read(OFF_MRA);
        bus_write(OFF_CRA, 8'h90);
        bus_read(OFF_MRA);
        bus_write(OFF_MRB, 8'hA5);
        bus_write(OFF_CRB, 8'h20);   // not the reset command: pointer stays
        bus_read(OFF_MRB);
        bus_write(OFF_CRB, 8'h10);
        bus_read(OFF_MRB);
    endtask

    // channel a transmit, channel b discard, interrupt with an idle word
    task automatic test_transmit_and_irq();
        dcr_in_t w;
        bus_write(OFF_RHRA, 8'hFF);
        bus_write(OFF_RHRA, 8'h00);
        bus_write(OFF_THRB, 8'h77);
        bus_write(OFF_IVR, 8'hFF);
        bus_write(OFF_ISR, 8'h03);
        w = '{opcode: OP_IDLE, reg_offset: 5'h1C, write_data: 8'hFF, rx_byte: 8'hFF};
        send_word(w);
        host_byte(8'hFF);
        bus_read(OFF_SRA);
        bus_read(OFF_ISR);
        bus_read(OFF_RHRA);
        bus_write(OFF_ISR, 8'h00);
    endtask

    // fill past full so bytes drop, then drain one past empty, with rxrdy interrupt
    task automatic test_fifo_overflow();
        bus_write(OFF_IVR, 8'h40);
        bus_write(OFF_ISR, 8'h02);
        repeat (RX_DEPTH + 2) host_byte(8'($urandom_range(0, 255)));
        bus_read(OFF_SRA);
        repeat (RX_DEPTH + 1) bus_read(OFF_RHRA);
        bus_read(OFF_ISR);
    endtask

    // mostly well-formed traffic: fill bursts, drain bursts, mode sequences
    task automatic test_random_traffic(input int n_words, input bit gaps, input bit stalls);
        int sent;
        int n;
        int unsigned kind;
        logic [4:0] mr_off;
        logic [4:0] cr_off;
        source_gaps = gaps;
        sink_stalls = stalls;
        sent = 0;
        while (sent < n_words) begin
            kind = $urandom_range(0, 99);
            if (kind < 12) begin
                n = $urandom_range(4, 20);
                repeat (n) host_byte(8'($urandom_range(0, 255)));
                sent += n;
            end else if (kind < 24) begin
                n = $urandom_range(3, 18);
                repeat (n) bus_read(OFF_RHRA);
                sent += n;
            end else if (kind < 32) begin
                mr_off = $urandom_range(0, 1) ? OFF_MRA : OFF_MRB;
                cr_off = (mr_off == OFF_MRA) ? OFF_CRA : OFF_CRB;
                bus_write(cr_off, {1'($urandom_range(0, 1)), CMD_RESET_MR,
                                   4'($urandom_range(0, 15))});
                bus_write(mr_off, 8'($urandom_range(0, 255)));
                bus_write(mr_off, 8'($urandom_range(0, 255)));
                bus_write(cr_off, {1'($urandom_range(0, 1)), CMD_RESET_MR,
                                   4'($urandom_range(0, 15))});
                bus_read(mr_off);
                bus_read(mr_off);
                sent += 6;
            end else if (kind < 36) begin
                bus_write(OFF_ISR, 8'($urandom_range(0, 255)));
                bus_write(OFF_IVR, 8'($urandom_range(0, 255)));
                sent += 2;
            end else begin
                send_word(rand_word());
                sent++;
            end
        end
        drain_results();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering,
    // so the block fills up and stalls its input
    task automatic test_output_backpressure();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        long_hold_req = 300;
        repeat (50) send_word(rand_word());
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        mr_a[0] = '0;
        mr_a[1] = '0;
        mr_b[0] = '0;
        mr_b[1] = '0;
        mr_a_ptr = 1'b0;
        mr_b_ptr = 1'b0;
        imr_shadow = '0;
        ivr_shadow = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_mode_pointers();
        test_transmit_and_irq();
        test_fifo_overflow();
        drain_results();
        test_random_traffic(300, 1'b1, 1'b1);
        test_random_traffic(200, 1'b0, 1'b0);
        test_output_backpressure();
        test_random_traffic(350, 1'b1, 1'b1);

        // let the clock run on to catch stray results
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("[duart_console_channel_regs_top] OK");
        end else begin
            $display("[duart_console_channel_regs_top] ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("[duart_console_channel_regs_top] ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/dcr_pkg.sv
rtl/core/dcr_rx_fifo.sv
rtl/core/dcr_chan_regs.sv
rtl/core/duart_console_channel_regs_top.sv
test/tb.sv
